[hw/rtl/delayed_sine_level_oscillator_unit_defines.svh]
// assertion helpers for the oscillator unit rtl
`ifndef DELAYED_SINE_LEVEL_OSCILLATOR_UNIT_DEFINES_SVH
`define DELAYED_SINE_LEVEL_OSCILLATOR_UNIT_DEFINES_SVH

// clocked property, off while reset is applied
`define DSLO_ASSERT(name_, prop_, msg_) \
  name_: assert property (@(posedge clk_i) disable iff (!rst_ni) prop_) else $error(msg_);

// condition that must never be seen
`define DSLO_ASSERT_NEVER(name_, cond_, msg_) \
  `DSLO_ASSERT(name_, !(cond_), msg_)

`endif

[hw/rtl/dslo_pkg.sv]
`default_nettype none

package dslo_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_BASELINE    = 2'd0,
    CFG_AMPLITUDE   = 2'd1,
    CFG_SPEED       = 2'd2,
    CFG_START_DELAY = 2'd3
  } cfg_idx_e;

  localparam int unsigned CFG_DATA_W = 25;

  // entries of the state memory
  localparam logic [0:0] ENT_DELAY = 1'b0;
  localparam logic [0:0] ENT_PHASE = 1'b1;
  localparam int unsigned STATE_W  = 32;
  localparam int unsigned STATE_D  = 2;

  // register reset values
  localparam logic signed [17:0] BASELINE_RST    = 18'sd32768;
  localparam logic signed [17:0] AMPLITUDE_RST   = 18'sd32768;
  localparam logic signed [24:0] SPEED_RST       = 25'sd4194304;
  localparam logic        [23:0] START_DELAY_RST = 24'd0;

  // sequencer states, one-hot
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DLY  = 7'b0000010,
    S_PH   = 7'b0000100,
    S_IDX  = 7'b0001000,
    S_SINE = 7'b0010000,
    S_MUL  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_e;

  // odd taylor coefficients of sin(pi/2 x), q30
  localparam logic [63:0] C1 = 64'd1686629713;
  localparam logic [63:0] C3 = 64'd693598668;
  localparam logic [63:0] C5 = 64'd85569306;
  localparam logic [63:0] C7 = 64'd5026995;
  localparam logic [63:0] C9 = 64'd172272;

  // quarter-wave value for x in q30, result q16 capped at 1.0
  function automatic logic [16:0] sine_poly(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    x2 = (x * x) >> 30;
    t  = (C9 * x2) >> 30;
    t  = C7 - t;
    t  = C5 - ((t * x2) >> 30);
    t  = C3 - ((t * x2) >> 30);
    t  = C1 - ((t * x2) >> 30);
    s  = (t * x) >> 30;
    s  = (s + 64'd8192) >> 14;
    if (s > 64'd65536) begin
      s = 64'd65536;
    end
    return s[16:0];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/dslo_ram.sv]
`default_nettype none

// simple dual-port ram, one write and one registered read per cycle
module dslo_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 2,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/delayed_sine_level_oscillator_unit.sv]
// channel   direction  handshake                 payload
// in        to block   in_valid_i / in_stall_o   time_step_i
// out       from block out_valid_o / out_stall_i level_o, clamped_o
// cfg       to block   cfg_we_i                  cfg_idx_i, cfg_data_i
//
// a step taken while the start delay runs only advances the delay count and gives no transfer out
// an oscillating step runs the transfer in, then delay read, phase
// read-modify-write, table index, table read, gain multiply and clamp, in that order
// the state words sit in a 2-entry ram; a valid bit per entry stands in for reset
// a held output register parks the next level in the clamp stage; the input stalls meanwhile
// asynchronous active-low reset, control and config registers back to their listed values

`default_nettype none

`include "delayed_sine_level_oscillator_unit_defines.svh"

module delayed_sine_level_oscillator_unit #(
  parameter int unsigned SINE_TABLE_DEPTH = 256
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration
  input  wire logic                            cfg_we_i,
  input  wire logic [1:0]                      cfg_idx_i,
  input  wire logic [dslo_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input channel
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [15:0]                     time_step_i,
  // output channel
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [15:0]                          level_o,
  output logic                                 clamped_o
);

  localparam int unsigned IdxW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int unsigned ProdW = 30 + IdxW;

  // constant quarter-wave table, entries 0..depth
  logic [16:0] sine_rom [SINE_TABLE_DEPTH+1];

  for (genvar gi = 0; gi <= SINE_TABLE_DEPTH; gi++) begin : g_sine
    localparam logic [63:0] X = (64'(gi) << 30) / SINE_TABLE_DEPTH;
    assign sine_rom[gi] = dslo_pkg::sine_poly(X);
  end

  // configuration registers
  logic signed [17:0] baseline_q;
  logic signed [17:0] amplitude_q;
  logic signed [24:0] speed_q;
  logic        [23:0] start_delay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      baseline_q    <= dslo_pkg::BASELINE_RST;
      amplitude_q   <= dslo_pkg::AMPLITUDE_RST;
      speed_q       <= dslo_pkg::SPEED_RST;
      start_delay_q <= dslo_pkg::START_DELAY_RST;
    end else if (cfg_we_i) begin
      case (dslo_pkg::cfg_idx_e'(cfg_idx_i))
        dslo_pkg::CFG_BASELINE:    baseline_q    <= cfg_data_i[17:0];
        dslo_pkg::CFG_AMPLITUDE:   amplitude_q   <= cfg_data_i[17:0];
        dslo_pkg::CFG_SPEED:       speed_q       <= cfg_data_i[24:0];
        dslo_pkg::CFG_START_DELAY: start_delay_q <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  // state memory
  logic                          ram_we;
  logic [0:0]                    ram_waddr;
  logic [dslo_pkg::STATE_W-1:0]  ram_wdata;
  logic                          ram_re;
  logic [0:0]                    ram_raddr;
  logic [dslo_pkg::STATE_W-1:0]  ram_rdata;

  dslo_ram #(
    .Width (dslo_pkg::STATE_W),
    .Depth (dslo_pkg::STATE_D)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // entry valid bits, an unwritten entry reads as zero
  logic [dslo_pkg::STATE_D-1:0] st_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_vld_q <= '0;
    end else if (ram_we) begin
      st_vld_q[ram_waddr] <= 1'b1;
    end
  end

  // sequencer and datapath registers
  dslo_pkg::state_e fsm_q, fsm_d;
  logic [15:0]        step_q;
  logic [31:0]        phase_q;
  logic [IdxW-1:0]    idx_q;
  logic               neg_q;
  logic [16:0]        sine_q;
  logic signed [35:0] prod_q;
  logic               out_valid_q;
  logic [15:0]        level_q;
  logic               clamped_q;

  logic in_xfer;
  logic out_load;

  assign in_stall_o = (fsm_q != dslo_pkg::S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_load   = (fsm_q == dslo_pkg::S_OUT) && !(out_valid_q && out_stall_i);

  // delay counter update
  logic [23:0] ds_cur;
  logic        waiting;
  logic [24:0] ds_sum;
  logic [23:0] ds_new;

  assign ds_cur  = st_vld_q[dslo_pkg::ENT_DELAY] ? ram_rdata[23:0] : 24'd0;
  assign waiting = ds_cur < start_delay_q;
  assign ds_sum  = {1'b0, ds_cur} + {9'd0, step_q};
  assign ds_new  = (ds_sum > {1'b0, start_delay_q}) ? start_delay_q : ds_sum[23:0];

  // phase advance
  logic [31:0]        ph_cur;
  logic signed [41:0] adv;
  logic [31:0]        ph_new;

  assign ph_cur = st_vld_q[dslo_pkg::ENT_PHASE] ? ram_rdata : 32'd0;
  assign adv    = $signed({1'b0, step_q}) * speed_q;
  assign ph_new = ph_cur + adv[31:0];

  // table index from the phase fraction
  logic [ProdW-1:0] idx_prod;
  logic [IdxW-1:0]  idx_raw;

  assign idx_prod = ProdW'(phase_q[29:0]) * ProdW'(SINE_TABLE_DEPTH);
  assign idx_raw  = idx_prod[ProdW-1:30];

  // signed sine and gain
  logic signed [17:0] sine_s;

  assign sine_s = neg_q ? -$signed({1'b0, sine_q}) : $signed({1'b0, sine_q});

  // rounding, offset and clamp
  logic signed [35:0] prod_rnd;
  logic signed [21:0] sum;

  assign prod_rnd = prod_q + 36'sd32768;
  assign sum      = 22'(baseline_q) + 22'($signed(prod_rnd[35:16]));

  // memory access control
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = dslo_pkg::ENT_DELAY;
    ram_we    = 1'b0;
    ram_waddr = dslo_pkg::ENT_DELAY;
    ram_wdata = {8'd0, ds_new};
    case (fsm_q)
      dslo_pkg::S_IDLE: begin
        ram_re = in_xfer;
      end
      dslo_pkg::S_DLY: begin
        if (waiting) begin
          ram_we = 1'b1;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = dslo_pkg::ENT_PHASE;
        end
      end
      dslo_pkg::S_PH: begin
        ram_we    = 1'b1;
        ram_waddr = dslo_pkg::ENT_PHASE;
        ram_wdata = ph_new;
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    fsm_d = fsm_q;
    case (fsm_q)
      dslo_pkg::S_IDLE: if (in_xfer) fsm_d = dslo_pkg::S_DLY;
      dslo_pkg::S_DLY:  fsm_d = waiting ? dslo_pkg::S_IDLE : dslo_pkg::S_PH;
      dslo_pkg::S_PH:   fsm_d = dslo_pkg::S_IDX;
      dslo_pkg::S_IDX:  fsm_d = dslo_pkg::S_SINE;
      dslo_pkg::S_SINE: fsm_d = dslo_pkg::S_MUL;
      dslo_pkg::S_MUL:  fsm_d = dslo_pkg::S_OUT;
      dslo_pkg::S_OUT:  if (out_load) fsm_d = dslo_pkg::S_IDLE;
      default:          fsm_d = dslo_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q <= dslo_pkg::S_IDLE;
    end else begin
      fsm_q <= fsm_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      step_q <= time_step_i;
    end
    if (fsm_q == dslo_pkg::S_PH) begin
      phase_q <= ph_new;
    end
    if (fsm_q == dslo_pkg::S_IDX) begin
      idx_q <= phase_q[30] ? IdxW'(SINE_TABLE_DEPTH) - idx_raw : idx_raw;
      neg_q <= phase_q[31];
    end
    if (fsm_q == dslo_pkg::S_SINE) begin
      sine_q <= sine_rom[idx_q];
    end
    if (fsm_q == dslo_pkg::S_MUL) begin
      prod_q <= amplitude_q * sine_s;
    end
    if (out_load) begin
      if (sum < 22'sd0) begin
        level_q   <= 16'd0;
        clamped_q <= 1'b1;
      end else if (sum > 22'sd65535) begin
        level_q   <= 16'hFFFF;
        clamped_q <= (sum > 22'sd65536);
      end else begin
        level_q   <= sum[15:0];
        clamped_q <= 1'b0;
      end
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign level_o     = level_q;
  assign clamped_o   = clamped_q;

  // checks
  `DSLO_ASSERT_NEVER(a_ram_rw_overlap, ram_we && ram_re, "state ram read and write overlap")
  `DSLO_ASSERT(a_phase_after_read,
               (fsm_q == dslo_pkg::S_PH) |->
                 ($past(fsm_q == dslo_pkg::S_DLY) && $past(ram_re)),
               "phase update without a phase read")
  `DSLO_ASSERT(a_out_from_clamp,
               $rose(out_valid_q) |-> $past(fsm_q == dslo_pkg::S_OUT),
               "output valid raised outside the clamp stage")
  `DSLO_ASSERT(a_clamp_level,
               (out_valid_o && clamped_o) |-> (level_o == 16'd0 || level_o == 16'hFFFF),
               "clamped level not at a rail")

endmodule

`default_nettype wire

[verif/delayed_sine_level_oscillator_unit_tb.sv]
`default_nettype none

module delayed_sine_level_oscillator_unit_tb;

  localparam int unsigned TABLE_DEPTH   = 256;
  localparam int          GAIN_MAX      = 131071;
  localparam int          GAIN_MIN      = -131072;
  localparam int          SPEED_MAX     = 16777215;
  localparam int          SPEED_MIN     = -16777216;
  localparam int          DELAY_MAX     = 16777215;
  localparam int          IDLE_PCT      = 27;
  localparam int          SETTLE_CYCLES = 16;
  localparam int          HOLD_CYCLES   = 400;
  localparam int          STALL_LIMIT   = 5000;
  localparam int          PHASE_ITEMS   = 125;
  localparam int          RANDOM_PHASES = 10;

  typedef struct packed {
    logic [15:0] level;
    logic        clamped;
  } level_result_t;

  // tracks oscillator state and holds the levels still owed by the block
  class level_tracker;
    logic signed [17:0] baseline;
    logic signed [17:0] amplitude;
    logic signed [24:0] speed;
    logic        [23:0] start_delay;
    logic        [23:0] delay_spent;
    logic        [31:0] phase;
    level_result_t      pending_levels[$];
    int unsigned        errors;

    function new();
      baseline    = dslo_pkg::BASELINE_RST;
      amplitude   = dslo_pkg::AMPLITUDE_RST;
      speed       = dslo_pkg::SPEED_RST;
      start_delay = dslo_pkg::START_DELAY_RST;
      delay_spent = '0;
      phase       = '0;
      errors      = 0;
    endfunction

    function void set_reg(dslo_pkg::cfg_idx_e idx,
                          logic [dslo_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        dslo_pkg::CFG_BASELINE:    baseline    = data[17:0];
        dslo_pkg::CFG_AMPLITUDE:   amplitude   = data[17:0];
        dslo_pkg::CFG_SPEED:       speed       = data[24:0];
        dslo_pkg::CFG_START_DELAY: start_delay = data[23:0];
        default: ;
      endcase
    endfunction

    // quarter-wave entry from the odd taylor series in q30, rounded to q16
    function int quarter_sine(logic [63:0] i);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      x  = (i << 30) / 64'(TABLE_DEPTH);
      x2 = (x * x) >> 30;
      t  = 64'd5026995 - ((64'd172272 * x2) >> 30);
      t  = 64'd85569306 - ((t * x2) >> 30);
      t  = 64'd693598668 - ((t * x2) >> 30);
      t  = 64'd1686629713 - ((t * x2) >> 30);
      s  = ((t * x) >> 30);
      s  = (s + 64'd8192) >> 14;
      if (s > 64'd65536) begin
        s = 64'd65536;
      end
      return int'(s);
    endfunction

    // signed sine of a phase, quadrant from the top two bits
    function int sine_at(logic [31:0] p);
      logic [63:0] idx;
      int          v;
      idx = ({34'b0, p[29:0]} * 64'(TABLE_DEPTH)) >> 30;
      if (p[30]) begin
        idx = 64'(TABLE_DEPTH) - idx;
      end
      v = quarter_sine(idx);
      return p[31] ? -v : v;
    endfunction

    // accepted time step: either delay bookkeeping or one new level
    function void note_step(logic [15:0] step);
      logic [31:0]   total;
      longint        prod;
      longint        sum;
      level_result_t res;
      if (delay_spent < start_delay) begin
        total       = {8'b0, delay_spent} + {16'b0, step};
        delay_spent = (total > {8'b0, start_delay}) ? start_delay : total[23:0];
        return;
      end
      phase = phase + 32'(longint'(step) * longint'(speed));
      prod  = longint'(amplitude) * longint'(sine_at(phase));
      sum   = longint'(baseline) + ((prod + 64'sd32768) >>> 16);
      if (sum < 0) begin
        res = '{level: 16'd0, clamped: 1'b1};
      end else if (sum > 65535) begin
        res = '{level: 16'hFFFF, clamped: (sum > 65536)};
      end else begin
        res = '{level: sum[15:0], clamped: 1'b0};
      end
      pending_levels.push_back(res);
    endfunction

    function void check_level(logic [15:0] level, logic clamped);
      level_result_t want;
      if (pending_levels.size() == 0) begin
        $display("%0t: unexpected level transfer, expected none, got level %0d clamped %0b",
                 $time, level, clamped);
        errors++;
        return;
      end
      want = pending_levels.pop_front();
      if (level !== want.level) begin
        $display("%0t: level mismatch, expected %0d, got %0d", $time, want.level, level);
        errors++;
      end
      if (clamped !== want.clamped) begin
        $display("%0t: clamped mismatch, expected %0b, got %0b",
                 $time, want.clamped, clamped);
        errors++;
      end
    endfunction
  endclass

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [1:0]                      cfg_idx_i;
  logic [dslo_pkg::CFG_DATA_W-1:0] cfg_data_i;
  logic                            in_valid_i;
  logic                            in_stall_o;
  logic [15:0]                     time_step_i;
  logic                            out_valid_o;
  logic                            out_stall_i;
  logic [15:0]                     level_o;
  logic                            clamped_o;

  level_tracker sb = new();
  bit           tx_quiet;
  bit           rx_quiet;
  bit           hold_req;
  int           idle_cycles;

  delayed_sine_level_oscillator_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .time_step_i (time_step_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .level_o     (level_o),
    .clamped_o   (clamped_o)
  );

  // clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // output side: random stalls, quiet stretches and one long hold-off
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_stall_i <= !rx_quiet && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // result check and progress watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        sb.check_level(level_o, clamped_o);
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // one time step transfer, with random idle cycles ahead of it
  task automatic send_step(input logic [15:0] step);
    while (!tx_quiet && ($urandom_range(0, 99) < IDLE_PCT)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    time_step_i <= step;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_step(step);
  endtask

  // stop offering, wait for every owed level, then let the block go idle
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending_levels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input dslo_pkg::cfg_idx_e idx,
                           input logic [dslo_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    sb.set_reg(idx, data);
    @(posedge clk_i);
  endtask

  // all four registers; unused high data bits of baseline, gain and delay carry noise
  task automatic apply_settings(input int base, input int gain, input int spd, input int dly);
    write_reg(dslo_pkg::CFG_BASELINE, {7'($urandom), base[17:0]});
    write_reg(dslo_pkg::CFG_AMPLITUDE, {7'($urandom), gain[17:0]});
    write_reg(dslo_pkg::CFG_SPEED, spd[24:0]);
    write_reg(dslo_pkg::CFG_START_DELAY, {1'($urandom), dly[23:0]});
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic int pick_gain();
    case ($urandom_range(0, 7))
      0:       return GAIN_MAX;
      1:       return GAIN_MIN;
      2:       return 0;
      3, 4:    return int'($urandom_range(0, 262143)) - 131072;
      default: return int'($urandom_range(0, 131072)) - 32768;
    endcase
  endfunction

  task automatic run_random_phase(input int n_items);
    int          spd;
    int          dly;
    logic [15:0] step;
    case ($urandom_range(0, 5))
      0:       spd = SPEED_MAX;
      1:       spd = SPEED_MIN;
      2:       spd = int'($urandom_range(0, 8191)) - 4096;
      default: spd = int'($urandom_range(0, 33554431)) - 16777216;
    endcase
    // delay mostly just ahead of what is already spent so the wait is reached
    case ($urandom_range(0, 5))
      0:       dly = 0;
      1:       dly = DELAY_MAX;
      default: dly = int'(sb.delay_spent) + int'($urandom_range(0, 4000));
    endcase
    // the hold-off phase oscillates at once so levels pile up
    if (hold_req) begin
      dly = int'(sb.delay_spent);
    end
    if (dly > DELAY_MAX) begin
      dly = DELAY_MAX;
    end
    apply_settings(pick_gain(), pick_gain(), spd, dly);
    for (int n = 0; n < n_items; n++) begin
      step = ($urandom_range(0, 9) < 7) ? 16'($urandom) : 16'($urandom_range(0, 64));
      send_step(step);
    end
    settle();
  endtask

  initial begin
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = dslo_pkg::CFG_BASELINE;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    time_step_i = '0;
    out_stall_i = 1'b0;
    idle_cycles = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: zero step and quadrant boundaries, then extremes
    send_step(16'd0);
    repeat (4) send_step(16'd256);
    send_step(16'hFFFF);
    send_step(16'd1);
    settle();

    // exactly full scale, just above it, just below zero
    apply_settings(65536, 0, SPEED_MAX, 0);
    send_step(16'd0);
    settle();
    apply_settings(65537, 0, SPEED_MAX, 0);
    send_step(16'd3);
    settle();
    apply_settings(-1, 0, SPEED_MIN, 0);
    send_step(16'd5);
    settle();

    // gain extremes at the lowest speed and at a speed of one
    apply_settings(GAIN_MAX, GAIN_MAX, SPEED_MIN, 0);
    send_step(16'hFFFF);
    send_step(16'd100);
    settle();
    apply_settings(GAIN_MIN, GAIN_MIN, 1, 0);
    send_step(16'd1);
    send_step(16'hFFFF);
    settle();

    // start delay used up over several steps, the overshoot dropped
    apply_settings(dslo_pkg::BASELINE_RST, dslo_pkg::AMPLITUDE_RST, dslo_pkg::SPEED_RST,
                   int'(sb.delay_spent) + 1000);
    repeat (4) send_step(16'd300);
    send_step(16'd100);
    settle();

    // raise the delay to its maximum, then lower it to end the wait
    apply_settings(dslo_pkg::BASELINE_RST, dslo_pkg::AMPLITUDE_RST, dslo_pkg::SPEED_RST,
                   DELAY_MAX);
    repeat (2) send_step(16'hFFFF);
    settle();
    apply_settings(dslo_pkg::BASELINE_RST, dslo_pkg::AMPLITUDE_RST, dslo_pkg::SPEED_RST,
                   int'(sb.delay_spent) + 10);
    send_step(16'hFFFF);
    send_step(16'd7);
    settle();

    // random phases, one with a long output hold-off, one with no idling
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      tx_quiet = (p == 3) || (p == 6);
      rx_quiet = (p == 6);
      hold_req = (p == 3);
      run_random_phase(PHASE_ITEMS);
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;

    if (sb.pending_levels.size() != 0) begin
      $display("%0t: %0d levels expected but never transferred, got none",
               $time, sb.pending_levels.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

[delayed_sine_level_oscillator_unit.f]
+incdir+hw/rtl
hw/rtl/dslo_pkg.sv
hw/rtl/dslo_ram.sv
hw/rtl/delayed_sine_level_oscillator_unit.sv
verif/delayed_sine_level_oscillator_unit_tb.sv
